// ----- hdl/spatio_temporal_dither_12to8_core_defines.svh -----
// Assertion macros shared by the checker.
`ifndef SPATIO_TEMPORAL_DITHER_12TO8_CORE_DEFINES_SVH
`define SPATIO_TEMPORAL_DITHER_12TO8_CORE_DEFINES_SVH

// Checked only outside reset.
`define STDTH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stdth check failed");

// Checked also across reset.
`define STDTH_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stdth reset check failed");

`endif

// ----- hdl/stdth_pkg.sv -----
package stdth_pkg;

  localparam int CH_W         = 12;
  localparam int OUT_W        = 8;
  localparam int DROP_BITS    = 4;
  localparam int PAIR_W       = 2;
  localparam int NUM_COLORS   = 3;
  localparam int NUM_FRAMES   = 4;
  localparam int SPAT_W       = PAIR_W * NUM_COLORS;

  localparam int LINE_WIDTH_W = 11;
  localparam int CFG_DATA_W   = 11;
  localparam int REG_INDEX_W  = 2;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd64;

  localparam logic [REG_INDEX_W-1:0] REG_LINE_WIDTH      = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_SCRAMBLE_ENABLE = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_SWAP_BIT_ROLES  = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic            frame_start;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] f0_red;
    logic [OUT_W-1:0] f0_green;
    logic [OUT_W-1:0] f0_blue;
    logic [OUT_W-1:0] f1_red;
    logic [OUT_W-1:0] f1_green;
    logic [OUT_W-1:0] f1_blue;
    logic [OUT_W-1:0] f2_red;
    logic [OUT_W-1:0] f2_green;
    logic [OUT_W-1:0] f2_blue;
    logic [OUT_W-1:0] f3_red;
    logic [OUT_W-1:0] f3_green;
    logic [OUT_W-1:0] f3_blue;
  } out_t;

endpackage

// ----- hdl/stdth_ram.sv -----
module stdth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/stdth_lane.sv -----
module stdth_lane (
  input  logic [stdth_pkg::OUT_W-1:0]  base,
  input  logic [stdth_pkg::PAIR_W-1:0] temp,
  input  logic [stdth_pkg::PAIR_W-1:0] spat,
  input  logic [1:0]                   start,
  input  logic [1:0]                   q,
  output logic [stdth_pkg::NUM_FRAMES-1:0][stdth_pkg::OUT_W-1:0] val
);

  logic [1:0]                  kk;
  logic [1:0]                  d;
  logic [1:0]                  qk;
  logic                        tadd;
  logic                        sadd;
  logic [stdth_pkg::OUT_W:0]   sum;

  always_comb begin
    kk   = '0;
    d    = '0;
    qk   = '0;
    tadd = 1'b0;
    sadd = 1'b0;
    sum  = '0;
    val  = '0;
    for (int k = 0; k < stdth_pkg::NUM_FRAMES; k++) begin
      kk = 2'(k);
      d  = kk - start;
      qk = q - kk;
      case (temp)
        2'd1: tadd = (d == 2'd0);
        2'd2: tadd = (d == 2'd0) || (d == 2'd2);
        2'd3: tadd = (d != 2'd3);
        default: tadd = 1'b0;
      endcase
      case (spat)
        2'd1: sadd = (q == kk);
        2'd2: sadd = kk[0] ? ((q == 2'd1) || (q == 2'd2)) : ((q == 2'd0) || (q == 2'd3));
        2'd3: sadd = (qk != 2'd3);
        default: sadd = 1'b0;
      endcase
      sum = {1'b0, base} + {{stdth_pkg::OUT_W{1'b0}}, tadd}
          + {{stdth_pkg::OUT_W{1'b0}}, sadd};
      val[k] = sum[stdth_pkg::OUT_W] ? {stdth_pkg::OUT_W{1'b1}} : sum[stdth_pkg::OUT_W-1:0];
    end
  end

endmodule

// ----- hdl/spatio_temporal_dither_12to8_core.sv -----
// A pixel's result passes through the stage 1 registers and then the output register.
// Throughput: one pixel per clock unless dith_ready holds the output; the line store RAM
// takes one write or one read per pixel, so the pipeline never stalls on its own.
// Reset (rst, synchronous): config back to width 64, scramble and swap on;
// column, row phase, tile corner and pipeline valids cleared; line store kept.
module spatio_temporal_dither_12to8_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pix_valid,
  output logic                                 pix_ready,
  input  stdth_pkg::in_t                       pix_data,
  output logic                                 dith_valid,
  input  logic                                 dith_ready,
  output stdth_pkg::out_t                      dith_data,
  input  logic                                 cfg_we,
  input  logic [stdth_pkg::REG_INDEX_W-1:0]    cfg_index,
  input  logic [stdth_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = (CW + 1 > stdth_pkg::LINE_WIDTH_W) ? CW + 1 : stdth_pkg::LINE_WIDTH_W;
  localparam logic [EW-1:0] WIDTH_LIM = EW'(MAX_WIDTH - (MAX_WIDTH % 2));
  localparam logic [EW-1:0] WIDTH_MIN = EW'(2);
  localparam int NC  = stdth_pkg::NUM_COLORS;
  localparam int PW  = stdth_pkg::PAIR_W;
  localparam int OW  = stdth_pkg::OUT_W;
  localparam int SW  = stdth_pkg::SPAT_W;

  // config registers
  logic [stdth_pkg::LINE_WIDTH_W-1:0] line_width;
  logic                               scramble_enable;
  logic                               swap_bit_roles;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width      <= stdth_pkg::LINE_WIDTH_RESET;
      scramble_enable <= 1'b1;
      swap_bit_roles  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        stdth_pkg::REG_LINE_WIDTH:      line_width      <= cfg_wdata[stdth_pkg::LINE_WIDTH_W-1:0];
        stdth_pkg::REG_SCRAMBLE_ENABLE: scramble_enable <= cfg_wdata[0];
        stdth_pkg::REG_SWAP_BIT_ROLES:  swap_bit_roles  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] width_even;
  logic [EW-1:0] eff_width;

  assign width_even = EW'({line_width[stdth_pkg::LINE_WIDTH_W-1:1], 1'b0});
  assign eff_width  = (width_even < WIDTH_MIN) ? WIDTH_MIN :
                      (width_even > WIDTH_LIM) ? WIDTH_LIM : width_even;

  // position state
  logic [CW-1:0] column_count;
  logic [1:0]    row_phase;
  logic [SW-1:0] tile_corner_bits;

  logic          accept;
  logic          adv_out;
  logic          s1_valid;

  logic [CW-1:0] col;
  logic [1:0]    row;
  logic [EW-1:0] col_inc;
  logic [CW-1:0] tile_full;
  logic [AW-1:0] tile_idx;
  logic          corner_write;
  logic          store_read;

  logic [NC-1:0][stdth_pkg::CH_W-1:0] ch;
  logic [NC-1:0][OW-1:0]              base_c;
  logic [NC-1:0][PW-1:0]              temp_c;
  logic [NC-1:0][1:0]                 start_c;
  logic [NC-1:0][1:0]                 q_c;
  logic [SW-1:0]                      own_spat;
  logic [1:0]                         pos;

  assign adv_out   = !dith_valid || dith_ready;
  assign pix_ready = !s1_valid || adv_out;
  assign accept    = pix_valid && pix_ready;

  assign col     = pix_data.frame_start ? '0 : column_count;
  assign row     = pix_data.frame_start ? 2'd0 : row_phase;
  assign col_inc = EW'(col) + EW'(1);
  assign pos     = {row[0], col[0]};

  assign ch = {pix_data.blue_in, pix_data.green_in, pix_data.red_in};

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      base_c[c]         = ch[c][stdth_pkg::CH_W-1:stdth_pkg::DROP_BITS];
      temp_c[c]         = swap_bit_roles ? ch[c][PW-1:0] : ch[c][2*PW-1:PW];
      own_spat[PW*c+:PW] = swap_bit_roles ? ch[c][2*PW-1:PW] : ch[c][PW-1:0];
      start_c[c]        = row + col[1:0] + (scramble_enable ? 2'(c) : 2'd0);
      q_c[c]            = pos - (scramble_enable ? 2'(c) : 2'd0);
    end
  end

  assign tile_full    = col >> 1;
  assign tile_idx     = (tile_full >= CW'(DEPTH)) ? AW'(DEPTH - 1) : AW'(tile_full);
  assign corner_write = accept && !row[0] && !col[0];
  assign store_read   = accept && row[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      row_phase        <= 2'd0;
      tile_corner_bits <= '0;
    end else if (accept) begin
      if (col_inc >= eff_width) begin
        column_count <= '0;
        row_phase    <= row + 2'd1;
      end else begin
        column_count <= CW'(col_inc);
        row_phase    <= row;
      end
      if (corner_write) begin
        tile_corner_bits <= own_spat;
      end
    end
  end

  logic [SW-1:0] store_rdata;

  stdth_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (corner_write),
    .waddr (tile_idx),
    .wdata (own_spat),
    .re    (store_read),
    .raddr (tile_idx),
    .rdata (store_rdata)
  );

  // stage 1
  logic [NC-1:0][OW-1:0] s1_base;
  logic [NC-1:0][PW-1:0] s1_temp;
  logic [NC-1:0][1:0]    s1_start;
  logic [NC-1:0][1:0]    s1_q;
  logic [SW-1:0]         s1_corner;
  logic                  s1_odd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_ready) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_base   <= base_c;
      s1_temp   <= temp_c;
      s1_start  <= start_c;
      s1_q      <= q_c;
      s1_corner <= corner_write ? own_spat : tile_corner_bits;
      s1_odd    <= row[0];
    end
  end

  // stage 2
  logic [SW-1:0] spat_all;
  logic [NC-1:0][stdth_pkg::NUM_FRAMES-1:0][OW-1:0] lane_val;
  stdth_pkg::out_t dith_next;

  assign spat_all = s1_odd ? store_rdata : s1_corner;

  for (genvar c = 0; c < NC; c++) begin : g_lane
    stdth_lane u_lane (
      .base  (s1_base[c]),
      .temp  (s1_temp[c]),
      .spat  (spat_all[PW*c+:PW]),
      .start (s1_start[c]),
      .q     (s1_q[c]),
      .val   (lane_val[c])
    );
  end

  always_comb begin
    dith_next.f0_red   = lane_val[0][0];
    dith_next.f0_green = lane_val[1][0];
    dith_next.f0_blue  = lane_val[2][0];
    dith_next.f1_red   = lane_val[0][1];
    dith_next.f1_green = lane_val[1][1];
    dith_next.f1_blue  = lane_val[2][1];
    dith_next.f2_red   = lane_val[0][2];
    dith_next.f2_green = lane_val[1][2];
    dith_next.f2_blue  = lane_val[2][2];
    dith_next.f3_red   = lane_val[0][3];
    dith_next.f3_green = lane_val[1][3];
    dith_next.f3_blue  = lane_val[2][3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dith_valid <= 1'b0;
    end else if (adv_out) begin
      dith_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      dith_data <= dith_next;
    end
  end

endmodule

// ----- hdl/stdth_checker.sv -----
`include "spatio_temporal_dither_12to8_core_defines.svh"

module stdth_checker (
  input logic            clk,
  input logic            rst,
  input logic            pix_valid,
  input logic            pix_ready,
  input logic            dith_valid,
  input logic            dith_ready,
  input stdth_pkg::out_t dith_data
);

  logic xfer_in;

  assign xfer_in = pix_valid && pix_ready;

  // a stalled result stays put
  `STDTH_ASSERT(a_hold_valid, dith_valid && !dith_ready |=> dith_valid)
  `STDTH_ASSERT(a_hold_data, dith_valid && !dith_ready |=> $stable(dith_data))

  // reset empties the output
  `STDTH_ASSERT_RST(a_reset_empty, rst |=> !dith_valid)

  // no result appears on an empty output without an earlier pixel transfer
  `STDTH_ASSERT(a_no_phantom, $past(!xfer_in && !dith_valid) && $past(!xfer_in, 2) |-> !dith_valid)

endmodule

bind spatio_temporal_dither_12to8_core stdth_checker u_stdth_checker (.*);
